>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL, included by ordered_position_set.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/ops_pkg.sv
// Shared types and constants of the ordered position set.
`default_nettype none

package ops_pkg;

   localparam int CAPACITY_DEF      = 64;
   localparam int POSITION_BITS_DEF = 9;

   localparam int OPCODE_W   = 3;
   localparam int POSITION_W = 9;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 7;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR    = 3'd0,
      OP_INSERT   = 3'd1,
      OP_ERASE    = 3'd2,
      OP_ERASE_AT = 3'd3,
      OP_CONTAINS = 3'd4,
      OP_READ     = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_CLEAR,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      PTR_ZERO,
      PTR_INDEX,
      PTR_NEXT_INDEX
   } ptr_sel_type;

   typedef struct packed {
      logic        load;
      ptr_sel_type ptr_sel;
      logic        advance;
      logic        shift_wr;
      logic        insert_wr;
      cnt_op_type  cnt_op;
      logic        rsp_load;
      logic        rsp_found;
      status_type  rsp_status;
      logic        rsp_use_rd;
   } ops_cmd_type;

   typedef struct packed {
      logic at_end;
      logic match;
      logic full;
      logic index_ok;
   } ops_sts_type;

endpackage

`default_nettype wire

>>> hw/rtl/ops_datapath.sv
// Entry memory, count, scan pointer and result register of the position set.
`default_nettype none

module ops_datapath
   import ops_pkg::*;
#(
   parameter int CAPACITY      = CAPACITY_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ops_cmd_type           cmd,
   output ops_sts_type                sts,
   input  wire logic [POSITION_W-1:0] position,
   input  wire logic [INDEX_W-1:0]    index,
   output logic                       rsp_found,
   output logic [POSITION_W-1:0]      rsp_read_position,
   output logic [COUNT_W-1:0]         rsp_count,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = POSITION_BITS;

   logic [PW-1:0] mem [CAPACITY];

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [PW-1:0] key_ff, key_in;
   logic [PW-1:0] rdata_ff;

   logic                  found_ff, found_in;
   logic [POSITION_W-1:0] rd_ff, rd_in;
   logic [COUNT_W-1:0]    cnt_out_ff, cnt_out_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic [31:0]   pos32, idx32, idx_next32, cnt32, rdata32;
   logic [CW-1:0] ptr_dec;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [PW-1:0] wr_data;

   assign pos32      = 32'(position);
   assign idx32      = 32'(index);
   assign idx_next32 = idx32 + 32'd1;
   assign rdata32    = 32'(rdata_ff);
   assign ptr_dec    = ptr_ff - CW'(1);

   assign sts.at_end   = (ptr_ff >= count_ff);
   assign sts.match    = (rdata_ff == key_ff);
   assign sts.full     = (32'(count_ff) >= 32'(CAPACITY));
   assign sts.index_ok = (idx32 < 32'(count_ff));

   always_comb begin
      key_in = cmd.load ? pos32[PW-1:0] : key_ff;

      ptr_in = ptr_ff;
      if (cmd.load) begin
         case (cmd.ptr_sel)
            PTR_ZERO:       ptr_in = '0;
            PTR_INDEX:      ptr_in = idx32[CW-1:0];
            PTR_NEXT_INDEX: ptr_in = idx_next32[CW-1:0];
            default:        ptr_in = '0;
         endcase
      end else if (cmd.advance) begin
         ptr_in = ptr_ff + CW'(1);
      end

      case (cmd.cnt_op)
         CNT_CLEAR: count_in = '0;
         CNT_INC:   count_in = count_ff + CW'(1);
         CNT_DEC:   count_in = count_ff - CW'(1);
         default:   count_in = count_ff;
      endcase
   end

   always_comb begin
      wr_en   = cmd.shift_wr | cmd.insert_wr;
      wr_addr = cmd.shift_wr ? ptr_dec[AW-1:0] : count_ff[AW-1:0];
      wr_data = cmd.shift_wr ? rdata_ff : key_ff;
   end

   always_comb begin
      cnt32      = 32'(count_in);
      found_in   = found_ff;
      rd_in      = rd_ff;
      cnt_out_in = cnt_out_ff;
      status_in  = status_ff;
      if (cmd.rsp_load) begin
         found_in   = cmd.rsp_found;
         rd_in      = cmd.rsp_use_rd ? rdata32[POSITION_W-1:0] : '0;
         cnt_out_in = cnt32[COUNT_W-1:0];
         status_in  = cmd.rsp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[ptr_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      found_ff   <= found_in;
      rd_ff      <= rd_in;
      cnt_out_ff <= cnt_out_in;
      status_ff  <= status_in;
   end

   assign rsp_found         = found_ff;
   assign rsp_read_position = rd_ff;
   assign rsp_count         = cnt_out_ff;
   assign rsp_status        = status_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ops_ctrl.sv
// Sequencer of the position set: decodes a request and steps the scan and shift.
`default_nettype none

module ops_ctrl
   import ops_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [OPCODE_W-1:0] opcode,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output ops_cmd_type              cmd,
   input  wire ops_sts_type         sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_READ,
      S_CLEAR,
      S_RANGE,
      S_NOP
   } state_type;

   state_type           state_ff, state_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      op_in    = op_ff;
      found_in = found_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               op_in    = opcode;
               found_in = 1'b0;
               case (opcode)
                  OP_INSERT, OP_ERASE, OP_CONTAINS: begin
                     cmd.ptr_sel = PTR_ZERO;
                     state_in    = S_SEARCH;
                  end
                  OP_ERASE_AT: begin
                     cmd.ptr_sel = PTR_NEXT_INDEX;
                     state_in    = sts.index_ok ? S_SHIFT : S_RANGE;
                  end
                  OP_READ: begin
                     cmd.ptr_sel = PTR_INDEX;
                     state_in    = sts.index_ok ? S_READ : S_RANGE;
                  end
                  OP_CLEAR: begin
                     state_in = S_CLEAR;
                  end
                  default: begin
                     state_in = S_NOP;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (sts.at_end) begin
               if (out_free) begin
                  cmd.rsp_load = 1'b1;
                  if (op_ff == OP_INSERT) begin
                     if (sts.full) begin
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        cmd.insert_wr = 1'b1;
                        cmd.cnt_op    = CNT_INC;
                     end
                  end
                  state_in = S_IDLE;
               end
            end else if (sts.match) begin
               if (op_ff == OP_ERASE) begin
                  cmd.advance = 1'b1;
                  found_in    = 1'b1;
                  state_in    = S_SHIFT;
               end else if (out_free) begin
                  cmd.rsp_load  = 1'b1;
                  cmd.rsp_found = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_SHIFT: begin
            if (sts.at_end) begin
               if (out_free) begin
                  cmd.rsp_load  = 1'b1;
                  cmd.rsp_found = found_ff;
                  cmd.cnt_op    = CNT_DEC;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.shift_wr = 1'b1;
               cmd.advance  = 1'b1;
            end
         end
         S_READ: begin
            if (out_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_use_rd = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_CLEAR: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.cnt_op   = CNT_CLEAR;
               state_in     = S_IDLE;
            end
         end
         S_RANGE: begin
            if (out_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_RANGE;
               state_in       = S_IDLE;
            end
         end
         S_NOP: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/ordered_position_set.sv
// Ordered position set: a list of distinct positions held in order, with
// clear, insert, erase by value, erase at index, contains and read requests.
// One request is worked at a time. Insert, erase and contains scan the entry
// memory one slot per clock through its single read port, and erase then
// moves every later entry down one slot per clock. Erase at index moves the
// entries above the index. The result register lets the next request be
// taken while a result waits on rsp_tready; a finished request holds only
// if the previous result is still not taken.
`default_nettype none

module ordered_position_set
   import ops_pkg::*;
#(
   parameter int CAPACITY      = CAPACITY_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // opcode [2:0], position [11:3], index [17:12], zero [23:18]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // found [0], read_position [9:1], count [16:10], status [18:17], zero [23:19]
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   `include "assert_macros.svh"

   ops_cmd_type cmd;
   ops_sts_type sts;

   logic                  rsp_found;
   logic [POSITION_W-1:0] rsp_read_position;
   logic [COUNT_W-1:0]    rsp_count;
   logic [STATUS_W-1:0]   rsp_status;

   ops_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (req_tdata[2:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   ops_datapath #(
      .CAPACITY      (CAPACITY),
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .position          (req_tdata[11:3]),
      .index             (req_tdata[17:12]),
      .rsp_found         (rsp_found),
      .rsp_read_position (rsp_read_position),
      .rsp_count         (rsp_count),
      .rsp_status        (rsp_status)
   );

   assign rsp_tdata = {5'd0, rsp_status, rsp_count, rsp_read_position, rsp_found};

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPLIES(a_full_not_found, clock, reset,
      rsp_tvalid && rsp_status == ST_FULL, !rsp_found)
   `ASSERT_IMPLIES(a_range_no_data, clock, reset,
      rsp_tvalid && rsp_status == ST_RANGE, rsp_read_position == '0 && !rsp_found)

endmodule

`default_nettype wire

>>> bench/tb_ordered_position_set.sv
// Testbench for the ordered position set: stream requests, predict each response, compare.
`timescale 1ns / 100ps

module tb_ordered_position_set
   import ops_pkg::*;
;

   localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;
   localparam int SET_CAPACITY = CAPACITY_DEF;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 4 * SET_CAPACITY;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      logic                  found;
      logic [POSITION_W-1:0] read_position;
      logic [COUNT_W-1:0]    count;
      status_type            status;
   } set_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // opcode [2:0], position [11:3], index [17:12], zero [23:18]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // found [0], read_position [9:1], count [16:10], status [18:17], zero [23:19]
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [POSITION_W-1:0] set_slots [SET_CAPACITY];
   int                    set_size = 0;
   set_result_type        pending_results [$];
   set_result_type        oldest_result;
   int                    mismatch_count = 0;
   int                    cycle_count    = 0;
   int                    send_idle_pct  = 0;
   int                    recv_stall_pct = 0;
   int                    hold_requests  = 0;
   int                    hold_served    = 0;

   ordered_position_set uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[ordered_position_set] ERROR");
         $finish;
      end
   end

   function automatic int find_slot(logic [POSITION_W-1:0] pos);
      for (int i = 0; i < set_size; i++)
         if (set_slots[i] == pos)
            return i;
      return set_size;
   endfunction

   function automatic void remove_slot(int slot);
      for (int i = slot; i + 1 < set_size; i++)
         set_slots[i] = set_slots[i + 1];
      set_size--;
   endfunction

   function automatic set_result_type apply_to_set(logic [OPCODE_W-1:0] op,
                                                   logic [POSITION_W-1:0] pos,
                                                   logic [INDEX_W-1:0] idx);
      set_result_type res;
      int             slot;
      res = '0;
      res.status = ST_DONE;
      case (op)
         OP_CLEAR: begin
            set_size = 0;
         end
         OP_INSERT: begin
            slot = find_slot(pos);
            if (slot < set_size) begin
               res.found = 1'b1;
            end else if (set_size >= SET_CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               set_slots[set_size] = pos;
               set_size++;
            end
         end
         OP_ERASE: begin
            slot = find_slot(pos);
            if (slot < set_size) begin
               res.found = 1'b1;
               remove_slot(slot);
            end
         end
         OP_ERASE_AT: begin
            if (int'(idx) < set_size)
               remove_slot(int'(idx));
            else
               res.status = ST_RANGE;
         end
         OP_CONTAINS: begin
            res.found = (find_slot(pos) < set_size);
         end
         OP_READ: begin
            if (int'(idx) < set_size)
               res.read_position = set_slots[idx];
            else
               res.status = ST_RANGE;
         end
         default: begin
         end
      endcase
      res.count = COUNT_W'(set_size);
      return res;
   endfunction

   task automatic send_request(input logic [OPCODE_W-1:0] op,
                               input logic [POSITION_W-1:0] pos,
                               input logic [INDEX_W-1:0] idx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {{(REQ_DATA_W - 18){1'b0}}, idx, pos, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_to_set(op, pos, idx));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("found", 16'(oldest_result.found), 16'(rsp_tdata[0]));
            check_field("read_position", 16'(oldest_result.read_position),
                        16'(rsp_tdata[9:1]));
            check_field("count", 16'(oldest_result.count), 16'(rsp_tdata[16:10]));
            check_field("status", 16'(oldest_result.status), 16'(rsp_tdata[18:17]));
            check_field("pad", 16'd0, 16'(rsp_tdata[RSP_DATA_W-1:19]));
         end
      end
   end

   task automatic test_directed_ops();
      send_request(OP_CLEAR, 9'd0, 6'd0);
      send_request(OP_READ, 9'd0, 6'd0);
      send_request(OP_ERASE_AT, 9'd0, 6'd63);
      send_request(OP_ERASE, 9'd0, 6'd0);
      send_request(OP_CONTAINS, 9'd511, 6'd0);
      send_request(OP_INSERT, 9'd0, 6'd0);
      send_request(OP_INSERT, 9'd511, 6'd63);
      send_request(OP_INSERT, 9'd0, 6'd0);
      send_request(OP_INSERT, 9'd170, 6'd21);
      send_request(OP_INSERT, 9'd341, 6'd42);
      send_request(OP_CONTAINS, 9'd511, 6'd0);
      send_request(OP_READ, 9'd0, 6'd0);
      send_request(OP_READ, 9'd0, 6'd3);
      send_request(OP_READ, 9'd0, 6'd63);
      send_request(OP_ERASE_AT, 9'd0, 6'd4);
      send_request(OP_ERASE, 9'd511, 6'd0);
      send_request(OP_ERASE, 9'd511, 6'd0);
      send_request(OP_ERASE_AT, 9'd0, 6'd0);
      send_request(OP_READ, 9'd0, 6'd1);
      send_request(OP_SPARE_6, 9'd511, 6'd63);
      send_request(OP_SPARE_7, 9'd0, 6'd0);
      send_request(OP_ERASE_AT, 9'd0, 6'd1);
      send_request(OP_CLEAR, 9'd511, 6'd63);
      send_request(OP_READ, 9'd0, 6'd0);
      wait_for_drain();
   endtask

   task automatic test_full_set();
      logic [POSITION_W-1:0] pos;
      send_request(OP_CLEAR, 9'd0, 6'd0);
      while (set_size < SET_CAPACITY) begin
         do pos = POSITION_W'($urandom_range(0, 511)); while (find_slot(pos) < set_size);
         send_request(OP_INSERT, pos, 6'($urandom_range(0, 63)));
      end
      do pos = POSITION_W'($urandom_range(0, 511)); while (find_slot(pos) < set_size);
      send_request(OP_INSERT, pos, 6'd0);
      send_request(OP_CONTAINS, pos, 6'd0);
      send_request(OP_INSERT, set_slots[17], 6'd0);
      send_request(OP_READ, 9'd0, 6'd63);
      send_request(OP_READ, 9'd0, 6'd0);
      send_request(OP_ERASE_AT, 9'd0, 6'd63);
      send_request(OP_READ, 9'd0, 6'd63);
      send_request(OP_ERASE_AT, 9'd0, 6'd0);
      send_request(OP_ERASE, set_slots[30], 6'd0);
      send_request(OP_CONTAINS, set_slots[set_size - 1], 6'd0);
      send_request(OP_INSERT, pos, 6'd0);
      send_request(OP_READ, 9'd0, 6'(set_size - 1));
      wait_for_drain();
   endtask

   task automatic random_request();
      int                    pick;
      logic [OPCODE_W-1:0]   op;
      logic [POSITION_W-1:0] pos;
      logic [INDEX_W-1:0]    idx;
      pick = $urandom_range(0, 99);
      if (pick < 1)       op = OP_CLEAR;
      else if (pick < 42) op = OP_INSERT;
      else if (pick < 54) op = OP_ERASE;
      else if (pick < 64) op = OP_ERASE_AT;
      else if (pick < 79) op = OP_CONTAINS;
      else if (pick < 96) op = OP_READ;
      else if (pick < 98) op = OP_SPARE_6;
      else                op = OP_SPARE_7;
      if (set_size > 0 && $urandom_range(0, 99) < (op == OP_INSERT ? 20 : 50))
         pos = set_slots[$urandom_range(0, set_size - 1)];
      else
         pos = POSITION_W'($urandom_range(0, 511));
      if (set_size > 0 && $urandom_range(0, 3) != 0)
         idx = INDEX_W'($urandom_range(0, set_size - 1));
      else
         idx = INDEX_W'($urandom_range(0, 63));
      send_request(op, pos, idx);
   endtask

   task automatic test_random_mix(input int n);
      repeat (n) random_request();
      wait_for_drain();
   endtask

   task automatic test_receiver_hold();
      int saved_idle;
      saved_idle = send_idle_pct;
      send_idle_pct = 0;
      hold_requests++;
      repeat (30) random_request();
      send_idle_pct = saved_idle;
      wait_for_drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 31;
      recv_stall_pct = 48;
      test_directed_ops();
      test_full_set();
      test_random_mix(450);

      send_idle_pct  = 48;
      recv_stall_pct = 31;
      test_receiver_hold();
      test_random_mix(420);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_mix(450);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ordered_position_set] OK");
      else
         $display("[ordered_position_set] ERROR");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ops_pkg.sv
hw/rtl/ops_datapath.sv
hw/rtl/ops_ctrl.sv
hw/rtl/ordered_position_set.sv
bench/tb_ordered_position_set.sv
